// File: src/stb_pkg.sv
// Package for the software timer bank: command and result transaction types,
// command codes, the timer expiry result and the uptime constant.
// Depends on nothing; every other file of the block imports it.
package stb_pkg;

    typedef enum logic [2:0] {
        MODE_TICK      = 3'd0,
        MODE_ARM       = 3'd1,
        MODE_DISARM    = 3'd2,
        MODE_TAKE_FLAG = 3'd3,
        MODE_READ_UP   = 3'd4,
        MODE_CLEAR_UP  = 3'd5
    } t_mode;

    localparam logic [9:0] MS_PER_SEC = 10'd1000;
    localparam logic [9:0] MS_LAST    = MS_PER_SEC - 10'd1;

    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  timer_index;
        logic [31:0] period;
        logic        periodic;
    } t_in_item;

    typedef struct packed {
        logic        status;
        logic        expired;
        logic [9:0]  milliseconds;
        logic [31:0] seconds;
    } t_out_item;

    typedef struct packed {
        logic [31:0] next_count;
        logic        fire;
        logic        disarm;
    } t_expiry;

endpackage

// File: src/stb_expiry_unit.sv
// Shared countdown unit of the timer bank: decrements one timer entry and
// decides expiry, reload and disarm. Depends on stb_pkg.
module stb_expiry_unit (
    input  logic [31:0]      i_count,
    input  logic [31:0]      i_period,
    input  logic             i_repeats,
    output stb_pkg::t_expiry o_result
);
    import stb_pkg::*;

    logic [31:0] w_dec;

    assign w_dec = i_count - 32'd1;

    always_comb begin
        o_result.fire       = (w_dec == 32'd0);
        // reload a periodic timer on expiry, else keep the decremented count
        o_result.next_count = (o_result.fire && i_repeats) ? i_period : w_dec;
        o_result.disarm     = o_result.fire && !i_repeats;
    end

endmodule

// File: src/software_timer_bank_unit.sv
// Top level of the software timer bank: command decode, uptime clock, timer
// memories and the tick sweep sequencer. Depends on stb_pkg, stb_expiry_unit.
//
// Usage:
//   Commands enter on the input channel (i_in_valid / o_in_ready, payload
//   i_in_data) and each produces exactly one result transaction on the output
//   channel (o_out_valid / i_out_ready, payload o_out_data).
//   Arm, disarm, take flag, read uptime, clear uptime and unused codes finish
//   in the accept cycle: the result is registered and shows in the next cycle.
//   A tick also posts its all-zero result in the next cycle, then sweeps the
//   timer memories, one entry per cycle through a registered read stage and
//   the shared countdown unit. A tick holds off further commands until the
//   sweep over the period and count memories has ended.
//   The input is ready only when no sweep runs and the output register is
//   empty or being taken in the same cycle, so a stalled receiver holds the
//   result and holds off further commands; nothing is dropped.
//   Reset (synchronous, active low) disarms all timers, clears flags, modes
//   and uptime at once through per-timer flip-flops; no clearing pass runs.
module software_timer_bank_unit #(
    parameter int TIMERS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  stb_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output stb_pkg::t_out_item o_out_data
);
    import stb_pkg::*;

    localparam int AW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int CW = $clog2(TIMERS + 1);

    typedef enum logic {
        ST_IDLE,
        ST_SWEEP
    } t_state;

    t_state r_state;

    // period and count memories; every entry is read in the sweep, only armed ones written back
    logic [31:0] r_mem_period [TIMERS];
    logic [31:0] r_mem_count  [TIMERS];
    logic [31:0] r_per_rd;
    logic [31:0] r_cnt_rd;

    // per-timer control bits in flip-flops, cleared by reset
    logic [TIMERS-1:0] r_armed;
    logic [TIMERS-1:0] r_flag;
    logic [TIMERS-1:0] r_repeats;

    logic [9:0]  r_ms;
    logic [31:0] r_sec;
    logic [9:0]  n_ms;
    logic [31:0] n_sec;

    logic [CW-1:0] r_sweep;
    logic          r_stg_vld;
    logic [AW-1:0] r_stg_idx;

    logic      r_out_valid;
    t_out_item r_out;

    logic      w_accept;
    logic      w_in_range;
    logic [AW-1:0] w_cmd_addr;
    logic      w_arm_ok;
    logic      w_issue;
    logic [AW-1:0] w_rd_addr;
    t_expiry   w_exp;
    t_out_item w_result;

    assign o_in_ready  = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_in_range = (32'(i_in_data.timer_index) < 32'(TIMERS));
    assign w_cmd_addr = AW'(i_in_data.timer_index);
    assign w_arm_ok   = w_in_range && (i_in_data.period != 32'd0);

    assign w_issue   = (r_state == ST_SWEEP) && (r_sweep < CW'(TIMERS));
    assign w_rd_addr = r_sweep[AW-1:0];

    // advance uptime; wrap milliseconds into seconds
    always_comb begin
        if (r_ms == MS_LAST) begin
            n_ms  = 10'd0;
            n_sec = r_sec + 32'd1;
        end else begin
            n_ms  = r_ms + 10'd1;
            n_sec = r_sec;
        end
    end

    // result of a command, taken in the accept cycle
    always_comb begin
        w_result = '0;
        unique case (i_in_data.mode)
            MODE_ARM:       w_result.status  = !w_arm_ok;
            MODE_TAKE_FLAG: w_result.expired = w_in_range && r_flag[w_cmd_addr];
            MODE_READ_UP: begin
                w_result.milliseconds = r_ms;
                w_result.seconds      = r_sec;
            end
            default: ;
        endcase
    end

    stb_expiry_unit u_expiry (
        .i_count   (r_cnt_rd),
        .i_period  (r_per_rd),
        .i_repeats (r_repeats[r_stg_idx]),
        .o_result  (w_exp)
    );

    // memory read port: one entry per sweep cycle, registered
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_per_rd <= r_mem_period[w_rd_addr];
            r_cnt_rd <= r_mem_count[w_rd_addr];
        end
    end

    // memory write port: arm in idle, countdown write-back during the sweep
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_in_data.mode == MODE_ARM) && w_arm_ok) begin
            r_mem_period[w_cmd_addr] <= i_in_data.period;
            r_mem_count[w_cmd_addr]  <= i_in_data.period;
        end else if (r_stg_vld && r_armed[r_stg_idx]) begin
            r_mem_count[r_stg_idx] <= w_exp.next_count;
        end
    end

    // sequencer, control bits, uptime and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_armed     <= '0;
            r_flag      <= '0;
            r_repeats   <= '0;
            r_ms        <= '0;
            r_sec       <= '0;
            r_sweep     <= '0;
            r_stg_vld   <= 1'b0;
            r_stg_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the result once taken, load a new one on accept
            if (w_accept) begin
                r_out_valid <= 1'b1;
                r_out       <= w_result;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        unique case (i_in_data.mode)
                            MODE_TICK: begin
                                r_ms    <= n_ms;
                                r_sec   <= n_sec;
                                r_sweep <= '0;
                                r_state <= ST_SWEEP;
                            end
                            MODE_ARM: begin
                                if (w_arm_ok) begin
                                    r_armed[w_cmd_addr]   <= 1'b1;
                                    r_flag[w_cmd_addr]    <= 1'b0;
                                    r_repeats[w_cmd_addr] <= i_in_data.periodic;
                                end
                            end
                            MODE_DISARM: begin
                                if (w_in_range) begin
                                    r_armed[w_cmd_addr] <= 1'b0;
                                    r_flag[w_cmd_addr]  <= 1'b0;
                                end
                            end
                            MODE_TAKE_FLAG: begin
                                if (w_in_range) begin
                                    r_flag[w_cmd_addr] <= 1'b0;
                                end
                            end
                            MODE_CLEAR_UP: begin
                                r_ms  <= '0;
                                r_sec <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SWEEP: begin
                    if (w_issue) begin
                        r_stg_vld <= 1'b1;
                        r_stg_idx <= w_rd_addr;
                        r_sweep   <= CW'(r_sweep + 1'b1);
                    end else begin
                        // last entry writes back this cycle
                        r_stg_vld <= 1'b0;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            // write back the entry in the stage
            if (r_stg_vld && r_armed[r_stg_idx]) begin
                if (w_exp.fire) begin
                    r_flag[r_stg_idx] <= 1'b1;
                end
                if (w_exp.disarm) begin
                    r_armed[r_stg_idx] <= 1'b0;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == ST_IDLE))
        else $error("input ready during a sweep");

    a_stage_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stg_vld |-> (r_state == ST_SWEEP))
        else $error("sweep stage active outside the sweep");

    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in_data.mode == MODE_TICK))
        |=> (o_out_valid && (o_out_data == '0) && (r_state == ST_SWEEP)))
        else $error("tick did not post a zero result and start the sweep");

    a_ms_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_accept) |-> (r_ms < MS_PER_SEC))
        else $error("millisecond count out of range");
`endif

endmodule
